>>> hw/rtl/hrs_pkg.sv
// Shared types and constants for the HTTP request header scanner.
// Used by the front classifier, the back scan engine and the top level.
// No dependencies.
`default_nettype none

package hrs_pkg;

   // Fixed widths of the external fields
   localparam int FIELD_W = 13;
   localparam int BYTE_W  = 8;

   // Reset value of the request length limit register
   localparam logic [FIELD_W-1:0] CSR_LIMIT_RESET = 13'd4094;

   // Queue depths between front, back and the result port
   localparam int TOK_QUEUE_DEPTH = 4;
   localparam int RSP_QUEUE_DEPTH = 2;

   // Header match window: 'C' at the oldest tap, 'L' eight bytes later
   localparam int WIN_DEPTH = 15;
   localparam int TAP_C     = 14;
   localparam int TAP_L     = 6;

   // Bytes of interest
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
   localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
   localparam logic [BYTE_W-1:0] CH_UP_C  = 8'h43;
   localparam logic [BYTE_W-1:0] CH_UP_L  = 8'h4C;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

   // Class of a byte as seen by the header window
   typedef enum logic [2:0] {
      CLS_OTHER = 3'd0,
      CLS_C     = 3'd1,
      CLS_L     = 3'd2,
      CLS_COLON = 3'd3,
      CLS_CR    = 3'd4,
      CLS_LF    = 3'd5
   } class_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_BAD_METHOD = 2'd1,
      ST_BAD_URI    = 2'd2,
      ST_TOO_LONG   = 2'd3
   } status_type;

   // Input beat
   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              first_byte;
   } req_type;

   // Result beat
   typedef struct packed {
      status_type         status;
      logic               is_post;
      logic [FIELD_W-1:0] uri_length;
      logic [FIELD_W-1:0] body_length;
      logic [FIELD_W-1:0] request_length;
   } rsp_type;

   // Classified byte passed from front to back
   typedef struct packed {
      logic      first_byte;
      class_type cls;
      logic      is_space;
      logic      is_slash;
      logic      is_blank;
      logic      is_digit;
      logic [3:0] digit;
   } tok_type;

endpackage

`default_nettype wire

>>> hw/rtl/http_request_header_scanner_top.sv
// Top level of the HTTP request header scanner.
// Uses hrs_pkg, hrs_front, hrs_fifo and hrs_back.
//
// Usage:
//   Request bytes enter on the req_ channel (push/full); a byte is taken at a
//   clock edge with req_push high and req_full low. req_item.first_byte marks
//   the start of a request. Results leave on the rsp_ channel: while
//   rsp_empty is low the oldest result is on rsp_item, and it is taken at an
//   edge with rsp_pop high. A request gives at most one result: at the blank
//   line for GET or for a POST without body, after the last body byte for
//   other POSTs, or on an error. Throughput is one byte per cycle while
//   req_full is low. A result reaches rsp_item through the token queue and
//   the result queue: the scan engine works on the token queue head and
//   writes the result queue at the next edge.
//   The csr_ port loads the request length limit (reset 4094); write it only
//   while no request is in flight.
//   Reset empties both queues and returns the scan engine to idle, so bytes
//   are ignored until a flagged first byte.
//   When the receiver stalls, the 2-entry result queue fills, the scan engine
//   holds, and the 4-entry token queue absorbs bytes until req_full rises.
`default_nettype none

module http_request_header_scanner_top
   import hrs_pkg::*;
#(
   parameter int MAX_REQUEST = 4096
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   input  wire req_type            req_item,
   output logic                    req_full,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output rsp_type                 rsp_item,
   input  wire logic               csr_we,
   input  wire logic [FIELD_W-1:0] csr_wdata
);

   logic [FIELD_W-1:0] limit_ff;

   logic    tok_push, tok_full, tok_empty, tok_pop;
   tok_type tok_in_item;
   logic [$bits(tok_type)-1:0] tok_out_bits;
   tok_type tok_out_item;

   logic    res_push, res_full;
   rsp_type res_item;
   logic [$bits(rsp_type)-1:0] rsp_bits;

   // Length limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= CSR_LIMIT_RESET;
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
      end
   end

   hrs_front u_front (
      .req_push (req_push),
      .req_item (req_item),
      .req_full (req_full),
      .tok_full (tok_full),
      .tok_push (tok_push),
      .tok_item (tok_in_item)
   );

   // Token queue between front and back
   hrs_fifo #(
      .WIDTH ($bits(tok_type)),
      .DEPTH (TOK_QUEUE_DEPTH)
   ) u_tok_queue (
      .clock (clock),
      .reset (reset),
      .push  (tok_push),
      .din   (tok_in_item),
      .full  (tok_full),
      .pop   (tok_pop),
      .dout  (tok_out_bits),
      .empty (tok_empty)
   );

   assign tok_out_item = tok_type'(tok_out_bits);

   hrs_back #(
      .MAX_REQUEST (MAX_REQUEST)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_limit (limit_ff),
      .tok_empty (tok_empty),
      .tok_item  (tok_out_item),
      .tok_pop   (tok_pop),
      .rsp_full  (res_full),
      .rsp_push  (res_push),
      .rsp_item  (res_item)
   );

   // Result queue toward the consumer
   hrs_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .din   (res_item),
      .full  (res_full),
      .pop   (rsp_pop),
      .dout  (rsp_bits),
      .empty (rsp_empty)
   );

   assign rsp_item = rsp_type'(rsp_bits);

endmodule

`default_nettype wire

>>> hw/rtl/hrs_fifo.sv
// Small register FIFO used for the token queue and the result queue.
// Depends on nothing; width and depth are parameters.
`default_nettype none

module hrs_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] din,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      dout,
   output logic                  empty
);

   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNTW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = slot_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/hrs_front.sv
// Front end: accepts request bytes and classifies them into tokens.
// Depends on hrs_pkg; feeds the token queue in front of the scan engine.
`default_nettype none

module hrs_front
   import hrs_pkg::*;
(
   input  wire logic    req_push,
   input  wire req_type req_item,
   output logic         req_full,
   input  wire logic    tok_full,
   output logic         tok_push,
   output tok_type      tok_item
);

   logic [BYTE_W-1:0] b;
   logic [BYTE_W-1:0] digit_off;

   assign b         = req_item.data_byte;
   assign digit_off = b - CH_ZERO;

   // Backpressure comes straight from the token queue
   assign req_full = tok_full;
   assign tok_push = req_push;

   // Byte classification
   always_comb begin
      tok_item.first_byte = req_item.first_byte;
      tok_item.is_space   = (b == CH_SPACE);
      tok_item.is_slash   = (b == CH_SLASH);
      tok_item.is_blank   = (b == CH_SPACE) || (b == CH_TAB);
      tok_item.is_digit   = (b >= CH_ZERO) && (b <= CH_NINE);
      tok_item.digit      = digit_off[3:0];
      case (b)
         CH_UP_C:  tok_item.cls = CLS_C;
         CH_UP_L:  tok_item.cls = CLS_L;
         CH_COLON: tok_item.cls = CLS_COLON;
         CH_CR:    tok_item.cls = CLS_CR;
         CH_LF:    tok_item.cls = CLS_LF;
         default:  tok_item.cls = CLS_OTHER;
      endcase
   end

endmodule

`default_nettype wire

>>> hw/rtl/hrs_back.sv
// Back end: scan engine that walks method, URI, header and body per token.
// Depends on hrs_pkg; pops the token queue and pushes the result queue.
`default_nettype none

module hrs_back
   import hrs_pkg::*;
#(
   parameter int MAX_REQUEST = 4096
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [FIELD_W-1:0] csr_limit,
   input  wire logic               tok_empty,
   input  wire tok_type            tok_item,
   output logic                    tok_pop,
   input  wire logic               rsp_full,
   output logic                    rsp_push,
   output rsp_type                 rsp_item
);

   localparam int CNT_RAW = $clog2(MAX_REQUEST + 2);
   localparam int CW      = (CNT_RAW > FIELD_W) ? CNT_RAW : FIELD_W;
   localparam int AW      = CW + 4;

   typedef enum logic [2:0] {
      PH_IDLE, PH_METHOD, PH_URI_FIRST, PH_URI, PH_HEADER, PH_BODY, PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      NUM_OFF, NUM_SKIP, NUM_LEAD, NUM_DIGITS
   } num_type;

   phase_type phase_ff, phase_in;
   num_type   num_ff, num_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] uri_ff, uri_in;
   logic [CW-1:0] len_ff, len_in;
   logic [CW-1:0] body_ff, body_in;
   logic          post_ff, post_in;
   class_type     win_ff [WIN_DEPTH];
   class_type     win_in [WIN_DEPTH];

   logic          go;
   logic          emit;
   status_type    emit_status;
   logic [CW-1:0] limit;
   logic [CW-1:0] csr_ext;
   logic [AW-1:0] acc;

   // Effective limit clamps the register at MAX_REQUEST
   assign csr_ext = CW'(csr_limit);
   assign limit   = (csr_ext > CW'(MAX_REQUEST)) ? CW'(MAX_REQUEST) : csr_ext;

   assign go      = !tok_empty && !rsp_full;
   assign tok_pop = go;

   // Per-token scan step
   always_comb begin
      phase_in    = phase_ff;
      num_in      = num_ff;
      count_in    = count_ff;
      uri_in      = uri_ff;
      len_in      = len_ff;
      body_in     = body_ff;
      post_in     = post_ff;
      win_in      = win_ff;
      emit        = 1'b0;
      emit_status = ST_OK;
      acc         = ({4'b0, len_ff} << 3) + ({4'b0, len_ff} << 1) + AW'(tok_item.digit);

      if (go) begin
         // A flagged first byte restarts the scan
         if (tok_item.first_byte) begin
            phase_in = PH_METHOD;
            num_in   = NUM_OFF;
            count_in = '0;
            uri_in   = '0;
            len_in   = '0;
            body_in  = '0;
            post_in  = 1'b0;
            for (int i = 0; i < WIN_DEPTH; i++) begin
               win_in[i] = CLS_OTHER;
            end
         end

         if (phase_in != PH_IDLE && phase_in != PH_DONE) begin
            count_in = count_in + 1'b1;
            if (count_in > limit) begin
               emit        = 1'b1;
               emit_status = ST_TOO_LONG;
            end else begin
               case (phase_in)
                  PH_METHOD: begin
                     if (count_in == CW'(4) && tok_item.is_space) begin
                        post_in  = 1'b0;
                        phase_in = PH_URI_FIRST;
                     end else if (count_in == CW'(5)) begin
                        if (!tok_item.is_space) begin
                           emit        = 1'b1;
                           emit_status = ST_BAD_METHOD;
                        end else begin
                           post_in  = 1'b1;
                           phase_in = PH_URI_FIRST;
                        end
                     end
                  end
                  PH_URI_FIRST: begin
                     if (!tok_item.is_slash) begin
                        emit        = 1'b1;
                        emit_status = ST_BAD_URI;
                     end else begin
                        uri_in   = CW'(1);
                        phase_in = PH_URI;
                     end
                  end
                  PH_URI: begin
                     if (tok_item.is_space) begin
                        for (int i = 0; i < WIN_DEPTH; i++) begin
                           win_in[i] = CLS_OTHER;
                        end
                        phase_in = PH_HEADER;
                     end else begin
                        uri_in = uri_in + 1'b1;
                     end
                  end
                  PH_HEADER: begin
                     // shift window, newest class at tap 0
                     for (int i = WIN_DEPTH - 1; i > 0; i--) begin
                        win_in[i] = win_ff[i-1];
                     end
                     win_in[0] = tok_item.cls;

                     // decimal length accumulate
                     case (num_ff)
                        NUM_SKIP: num_in = NUM_LEAD;
                        NUM_LEAD, NUM_DIGITS: begin
                           if (tok_item.is_digit) begin
                              len_in = (acc > AW'(MAX_REQUEST)) ? CW'(MAX_REQUEST)
                                                                : acc[CW-1:0];
                              num_in = NUM_DIGITS;
                           end else if (num_ff == NUM_LEAD && tok_item.is_blank) begin
                              num_in = NUM_LEAD;
                           end else begin
                              num_in = NUM_OFF;
                           end
                        end
                        default: num_in = num_ff;
                     endcase

                     // length field name seen: restart the number
                     if (win_in[TAP_C] == CLS_C && win_in[TAP_L] == CLS_L &&
                         win_in[0] == CLS_COLON) begin
                        len_in = '0;
                        num_in = NUM_SKIP;
                     end

                     // blank line ends the header
                     if (win_in[3] == CLS_CR && win_in[2] == CLS_LF &&
                         win_in[1] == CLS_CR && win_in[0] == CLS_LF) begin
                        num_in = NUM_OFF;
                        if (!post_in || len_in == '0) begin
                           emit = 1'b1;
                        end else begin
                           body_in  = len_in;
                           phase_in = PH_BODY;
                        end
                     end
                  end
                  PH_BODY: begin
                     if (body_in != '0) begin
                        body_in = body_in - 1'b1;
                     end
                     if (body_in == '0) begin
                        emit = 1'b1;
                     end
                  end
                  default: phase_in = phase_in;
               endcase
            end
            if (emit) begin
               phase_in = PH_DONE;
            end
         end
      end
   end

   // Result beat toward the result queue
   assign rsp_push                = emit;
   assign rsp_item.status         = emit_status;
   assign rsp_item.is_post        = post_in;
   assign rsp_item.uri_length     = uri_in[FIELD_W-1:0];
   assign rsp_item.body_length    = len_in[FIELD_W-1:0];
   assign rsp_item.request_length = count_in[FIELD_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         num_ff   <= NUM_OFF;
         count_ff <= '0;
         uri_ff   <= '0;
         len_ff   <= '0;
         body_ff  <= '0;
         post_ff  <= 1'b0;
         for (int i = 0; i < WIN_DEPTH; i++) begin
            win_ff[i] <= CLS_OTHER;
         end
      end else begin
         phase_ff <= phase_in;
         num_ff   <= num_in;
         count_ff <= count_in;
         uri_ff   <= uri_in;
         len_ff   <= len_in;
         body_ff  <= body_in;
         post_ff  <= post_in;
         win_ff   <= win_in;
      end
   end

endmodule

`default_nettype wire

>>> tb/http_scan_checker.sv
// Result checker for the HTTP request header scanner: follows accepted request
// beats and limit writes, predicts each result and compares every popped one.
// Depends on hrs_pkg for the beat types, status codes and byte constants.

module http_scan_checker
   import hrs_pkg::*;
#(
   parameter int MAX_REQUEST = 4096
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   input  wire logic               req_full,
   input  wire req_type            req_item,
   input  wire logic               rsp_empty,
   input  wire logic               rsp_pop,
   input  wire rsp_type            rsp_item,
   input  wire logic               csr_we,
   input  wire logic [FIELD_W-1:0] csr_wdata,
   output int                      fail_count,
   output int                      results_due_count
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [FIELD_W-1:0] LIMIT_CAP = FIELD_W'(MAX_REQUEST);

   typedef enum logic [2:0] {
      SCAN_IDLE,
      SCAN_METHOD,
      SCAN_URI_FIRST,
      SCAN_URI,
      SCAN_HEADER,
      SCAN_BODY,
      SCAN_DONE
   } scan_state_type;

   typedef enum logic [1:0] {
      NUM_OFF,
      NUM_SKIP,
      NUM_LEAD,
      NUM_DIGITS
   } number_state_type;

   // Predicted scanner state
   logic [FIELD_W-1:0] limit_reg;
   scan_state_type     scan_state;
   number_state_type   num_state;
   logic [FIELD_W-1:0] byte_count;
   logic [FIELD_W-1:0] uri_count;
   logic [FIELD_W-1:0] length_value;
   logic [FIELD_W-1:0] body_left;
   logic               post_flag;
   logic [BYTE_W-1:0]  window [WIN_DEPTH];

   // Results predicted but not yet popped, oldest first
   rsp_type results_due[$];

   int fail_total = 0;
   int due_total  = 0;

   assign fail_count        = fail_total;
   assign results_due_count = due_total;

   // Per-request state, cleared on reset and on a flagged first byte
   task automatic clear_request();
      byte_count   = '0;
      uri_count    = '0;
      length_value = '0;
      body_left    = '0;
      post_flag    = 1'b0;
      num_state    = NUM_OFF;
      for (int i = 0; i < WIN_DEPTH; i++) window[i] = '0;
   endtask

   // Close the request with a result; the scan then waits for a first byte
   task automatic finish_request(input status_type st);
      rsp_type r;
      r.status         = st;
      r.is_post        = post_flag;
      r.uri_length     = uri_count;
      r.body_length    = length_value;
      r.request_length = byte_count;
      results_due.push_back(r);
      scan_state = SCAN_DONE;
   endtask

   // Advance the predicted scan by one request byte
   task automatic scan_byte(input logic [BYTE_W-1:0] b, input logic first);
      logic [FIELD_W-1:0] limit;
      int unsigned        acc;
      limit = (limit_reg > LIMIT_CAP) ? LIMIT_CAP : limit_reg;
      if (first) begin
         clear_request();
         scan_state = SCAN_METHOD;
      end
      if (scan_state == SCAN_IDLE || scan_state == SCAN_DONE) return;

      byte_count = byte_count + 1'b1;
      if (byte_count > limit) begin
         finish_request(ST_TOO_LONG);
         return;
      end

      case (scan_state)
         SCAN_METHOD: begin
            // space as 4th byte: GET, as 5th byte: POST
            if (byte_count == 4 && b == CH_SPACE) begin
               post_flag  = 1'b0;
               scan_state = SCAN_URI_FIRST;
            end else if (byte_count == 5) begin
               if (b != CH_SPACE) begin
                  finish_request(ST_BAD_METHOD);
                  return;
               end
               post_flag  = 1'b1;
               scan_state = SCAN_URI_FIRST;
            end
         end
         SCAN_URI_FIRST: begin
            if (b != CH_SLASH) begin
               finish_request(ST_BAD_URI);
               return;
            end
            uri_count  = FIELD_W'(1);
            scan_state = SCAN_URI;
         end
         SCAN_URI: begin
            // window starts empty so only header bytes can match
            if (b == CH_SPACE) begin
               for (int i = 0; i < WIN_DEPTH; i++) window[i] = '0;
               scan_state = SCAN_HEADER;
            end else begin
               uri_count = uri_count + 1'b1;
            end
         end
         SCAN_HEADER: begin
            for (int i = WIN_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
            window[0] = b;
            // content length digits, saturating
            case (num_state)
               NUM_SKIP: num_state = NUM_LEAD;
               NUM_LEAD, NUM_DIGITS: begin
                  if (b >= CH_ZERO && b <= CH_NINE) begin
                     acc = length_value * 10 + (b - CH_ZERO);
                     length_value = (acc > MAX_REQUEST) ? LIMIT_CAP : acc[FIELD_W-1:0];
                     num_state = NUM_DIGITS;
                  end else if (!(num_state == NUM_LEAD && (b == CH_SPACE || b == CH_TAB))) begin
                     num_state = NUM_OFF;
                  end
               end
               default: ;
            endcase
            // length field match restarts the number
            if (window[TAP_C] == CH_UP_C && window[TAP_L] == CH_UP_L &&
                window[0] == CH_COLON) begin
               length_value = '0;
               num_state    = NUM_SKIP;
            end
            // blank line ends the header
            if (window[3] == CH_CR && window[2] == CH_LF &&
                window[1] == CH_CR && window[0] == CH_LF) begin
               num_state = NUM_OFF;
               if (!post_flag || length_value == 0) begin
                  finish_request(ST_OK);
                  return;
               end
               body_left  = length_value;
               scan_state = SCAN_BODY;
            end
         end
         default: begin
            if (body_left > 0) body_left = body_left - 1'b1;
            if (body_left == 0) finish_request(ST_OK);
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [FIELD_W-1:0] want,
                              input logic [FIELD_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_total++;
      end
   endtask

   // Sample both channels and the limit port at each rising edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_request();
         scan_state = SCAN_IDLE;
         limit_reg  = CSR_LIMIT_RESET;
         results_due.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (results_due.size() == 0) begin
               $display("%0t: result beat with none expected, expected none, actual %p",
                        $time, rsp_item);
               fail_total++;
            end else begin
               want = results_due.pop_front();
               check_field("status", FIELD_W'(want.status), FIELD_W'(rsp_item.status));
               check_field("is_post", FIELD_W'(want.is_post), FIELD_W'(rsp_item.is_post));
               check_field("uri_length", want.uri_length, rsp_item.uri_length);
               check_field("body_length", want.body_length, rsp_item.body_length);
               check_field("request_length", want.request_length, rsp_item.request_length);
            end
         end
         if (csr_we) limit_reg = csr_wdata;
         if (req_push && !req_full) scan_byte(req_item.data_byte, req_item.first_byte);
      end
      due_total = results_due.size();
   end

endmodule

>>> tb/tb_top.sv
// Top of the HTTP request header scanner testbench: clock, reset, request and
// limit stimulus, receiver stalls, timeout and verdict.
// Depends on hrs_pkg, http_request_header_scanner_top and http_scan_checker.

module tb_top
   import hrs_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          MAX_REQUEST  = 4096;
   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          PHASE_BUDGET = 160;
   localparam int          NUM_PHASES   = 7;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_push  = 1'b0;
   req_type            req_item  = '0;
   logic               rsp_pop   = 1'b0;
   logic               csr_we    = 1'b0;
   logic [FIELD_W-1:0] csr_wdata = '0;
   logic               req_full;
   logic               rsp_empty;
   rsp_type            rsp_item;
   int                 fail_count;
   int                 results_due_count;

   int unsigned        cycle_count = 0;
   int                 bytes_sent  = 0;
   bit                 sender_gaps = 1'b0;
   bit                 hold_rsp    = 1'b0;
   logic [BYTE_W-1:0]  req_bytes[$];
   int unsigned        phase_limits[NUM_PHASES];

   always #1 clock = ~clock;

   http_request_header_scanner_top #(
      .MAX_REQUEST(MAX_REQUEST)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_item  (req_item),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   http_scan_checker #(
      .MAX_REQUEST(MAX_REQUEST)
   ) scan_check (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_item          (req_item),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_item          (rsp_item),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .fail_count        (fail_count),
      .results_due_count (results_due_count)
   );

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[http_request_header_scanner_top] ERROR");
         $finish;
      end
   end

   // Receiver: random pops, eager stretches, and a long hold on request
   initial begin
      int stall_left;
      int mode_left;
      bit eager;
      stall_left = 0;
      mode_left  = 0;
      eager      = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end else begin
            if (mode_left == 0) begin
               eager     = ($urandom_range(0, 3) == 0);
               mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            if (stall_left > 0) begin
               stall_left--;
               rsp_pop <= 1'b0;
            end else if (!eager && $urandom_range(0, 3) == 0) begin
               stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                        : $urandom_range(0, 2);
               rsp_pop <= 1'b0;
            end else begin
               rsp_pop <= 1'b1;
            end
         end
      end
   end

   // One request beat, with an optional gap in front; waits for acceptance
   task automatic push_byte(input logic [BYTE_W-1:0] b, input logic first);
      int      gap;
      req_type item;
      gap = 0;
      if (sender_gaps && $urandom_range(0, 3) == 0)
         gap = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
      if (gap > 0) begin
         @(negedge clock);
         req_push <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      item.data_byte  = b;
      item.first_byte = first;
      @(negedge clock);
      req_push <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (req_full);
      bytes_sent++;
   endtask

   // Stray first flags inside a request break it up
   task automatic send_request(input bit stray);
      for (int i = 0; i < req_bytes.size(); i++)
         push_byte(req_bytes[i], (i == 0) || (stray && $urandom_range(0, 15) == 0));
   endtask

   // Sender stops until every predicted result is out, then lets the pipe settle
   task automatic drain_results();
      @(negedge clock);
      req_push <= 1'b0;
      while (results_due_count != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_limit(input int unsigned value);
      drain_results();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= FIELD_W'(value);
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic add_byte(input logic [BYTE_W-1:0] b);
      req_bytes.push_back(b);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) req_bytes.push_back(s[i]);
   endtask

   function automatic logic [BYTE_W-1:0] non_space_byte();
      logic [BYTE_W-1:0] b;
      do b = BYTE_W'($urandom_range(0, 255)); while (b == CH_SPACE);
      return b;
   endfunction

   // Content length line in assorted syntax; returns the body size to send
   task automatic add_length_field(output int body_n);
      int v;
      int form;
      add_text("Content-Length:");
      // the byte after the colon is skipped whatever it is
      add_byte(($urandom_range(0, 3) == 0) ? BYTE_W'($urandom_range(0, 255)) : CH_SPACE);
      repeat ($urandom_range(0, 2)) add_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
      form   = $urandom_range(0, 9);
      v      = $urandom_range(0, 24);
      body_n = v;
      case (form)
         0: begin
            add_text("-");
            add_text($sformatf("%0d", v));
            body_n = 0;
         end
         1: begin
            add_text("0x");
            add_text($sformatf("%0d", v));
            body_n = 0;
         end
         2: begin
            // saturates; the body is cut short by the next request
            add_text($sformatf("%0d", $urandom_range(4097, 99999)));
            body_n = $urandom_range(0, 20);
         end
         3: begin
            add_text($sformatf("%0d", v));
            add_byte(BYTE_W'($urandom_range(0, 255)));
         end
         4: body_n = 0;
         default: add_text($sformatf("%0d", v));
      endcase
      add_text("\r\n");
   endtask

   // GET or POST with a random uri, headers and body
   task automatic build_wellformed();
      bit post;
      int body_n;
      int n_hdr;
      post   = ($urandom_range(0, 1) == 1);
      body_n = 0;
      if (post) add_text("POST /"); else add_text("GET /");
      repeat ($urandom_range(0, 8)) add_byte(non_space_byte());
      add_text(" ");
      if ($urandom_range(0, 1)) add_text("HTTP/1.1\r\n");
      n_hdr = $urandom_range(0, 3);
      repeat (n_hdr) begin
         case ($urandom_range(0, 5))
            0: add_text("Host: h\r\n");
            1: begin
               repeat ($urandom_range(1, 10)) add_byte(BYTE_W'($urandom_range(0, 255)));
               add_text("\r\n");
            end
            2: add_text("Content-length: 7\r\n");
            default: add_length_field(body_n);
         endcase
      end
      add_text("\r\n");
      if (post) begin
         if ($urandom_range(0, 7) == 0) body_n = body_n + $urandom_range(0, 3);
         repeat (body_n) add_byte(BYTE_W'($urandom_range(0, 255)));
      end else begin
         // trailing bytes after a GET header are ignored
         repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 4))
            add_byte(BYTE_W'($urandom_range(0, 255)));
      end
   endtask

   task automatic build_random_request(output bit stray);
      int               pick;
      int               cut;
      logic [BYTE_W-1:0] b;
      req_bytes.delete();
      stray = 1'b0;
      pick  = $urandom_range(0, 99);
      if (pick < 62) begin
         build_wellformed();
         if ($urandom_range(0, 9) == 0) begin
            cut = $urandom_range(1, req_bytes.size());
            while (req_bytes.size() > cut) void'(req_bytes.pop_back());
         end
      end else if (pick < 70) begin
         if ($urandom_range(0, 1)) add_text("GET / \r\n\r\n");
         else add_text("POST / \r\n\r\n");
      end else if (pick < 79) begin
         // no space as 4th or 5th byte
         repeat (3) add_byte(BYTE_W'($urandom_range(0, 255)));
         add_byte(non_space_byte());
         add_byte(non_space_byte());
         repeat ($urandom_range(0, 3)) add_byte(BYTE_W'($urandom_range(0, 255)));
      end else if (pick < 87) begin
         if ($urandom_range(0, 1)) add_text("GET "); else add_text("POST ");
         do b = BYTE_W'($urandom_range(0, 255)); while (b == CH_SLASH);
         add_byte(b);
         repeat ($urandom_range(0, 3)) add_byte(BYTE_W'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 12)) add_byte(BYTE_W'($urandom_range(0, 255)));
         stray = 1'b1;
      end
   endtask

   task automatic run_random(input int budget);
      int start;
      bit stray;
      start = bytes_sent;
      while (bytes_sent - start < budget) begin
         build_random_request(stray);
         sender_gaps = ($urandom_range(0, 9) >= 3);
         send_request(stray);
         if ($urandom_range(0, 19) == 0) drain_results();
      end
   endtask

   // Main stimulus
   initial begin
      phase_limits = '{16, 4096, 17, $urandom_range(18, 64), 4095,
                       $urandom_range(65, 400), 4094};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: ignored beats, minimal GET, bad method, bad uri, byte extremes
      sender_gaps = 1'b0;
      push_byte(8'h00, 1'b0);
      req_bytes.delete();
      add_text("GET / \r\n\r\n");
      send_request(1'b0);
      req_bytes.delete();
      add_text("PATCH");
      send_request(1'b0);
      push_byte(8'hFF, 1'b0);
      req_bytes.delete();
      add_text("GET x");
      send_request(1'b0);

      for (int p = 0; p < NUM_PHASES; p++) begin
         set_limit(phase_limits[p]);
         if (p == 0) begin
            // receiver holds off while short requests keep coming
            hold_rsp    = 1'b1;
            sender_gaps = 1'b0;
            repeat (12) begin
               req_bytes.delete();
               add_text("GET / \r\n\r\n");
               send_request(1'b0);
            end
         end
         if (phase_limits[p] == MAX_REQUEST) begin
            // saturated length; the body is cut short by the next request
            req_bytes.delete();
            add_text("POST /big \r\nContent-Length: 99999\r\n\r\n");
            repeat (64) add_byte(BYTE_W'($urandom_range(0, 255)));
            sender_gaps = 1'b0;
            send_request(1'b0);
         end
         run_random(PHASE_BUDGET);
      end

      drain_results();
      repeat (16) @(negedge clock);
      if (fail_count == 0) begin
         $display("[http_request_header_scanner_top] OK");
      end else begin
         $display("[http_request_header_scanner_top] ERROR");
      end
      $finish;
   end

endmodule
